// ===== sv/hpt_pkg.sv =====
// shared types and constants of the homogeneous point transform
// no dependencies
package hpt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_COMP   = 3;
    localparam int NUM_ROWS   = 4;
    localparam int COEF_SLOT  = 16;
    localparam int FRAC_SHIFT = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_ONE   = 3'd0,
        REG_ROW_TWO   = 3'd1,
        REG_ROW_THREE = 3'd2,
        REG_ROW_FOUR  = 3'd3
    } t_reg_idx;

    localparam logic [CFG_DATA_W-1:0] ROW_ONE_RST   = 64'h0000_0000_0000_1000;
    localparam logic [CFG_DATA_W-1:0] ROW_TWO_RST   = 64'h0000_0000_1000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW_THREE_RST = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW_FOUR_RST  = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic [NUM_COMP-1:0] neg;
        logic                fault;
    } t_side;

endpackage

// ===== sv/hpt_point_if.sv =====
// valid/ready channel carrying one input point word
// no dependencies
interface hpt_point_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source(output valid, point_x, point_y, point_z, input ready);
    modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

// ===== sv/hpt_result_if.sv =====
// valid/ready channel carrying one transformed point word
// no dependencies
interface hpt_result_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] result_x;
    logic signed [COORD_WIDTH-1:0] result_y;
    logic signed [COORD_WIDTH-1:0] result_z;
    logic                          divide_fault;
    logic                          saturated;

    modport source(output valid, result_x, result_y, result_z, divide_fault, saturated,
                   input ready);
    modport sink(input valid, result_x, result_y, result_z, divide_fault, saturated,
                 output ready);
endinterface

// ===== sv/homogeneous_point_transform_unit.sv =====
// 4x4 matrix point transform with perspective divide, pipelined
// depends on hpt_pkg, hpt_point_if, hpt_result_if, hpt_div_stage
//
// usage: points enter on i_point (valid/ready), one word per cycle unless stalled;
// results leave on o_result in the same order, one word per input word.
// the matrix is written through i_cfg_we/i_cfg_idx/i_cfg_data, one row per write; the user
// must write only while the pipeline is empty, the block does not enforce it; indexes above three are ignored.
// pipeline: accept to result valid passes through the multiply, column sum,
// magnitude, COORD_WIDTH+1 divide stages and the output register. the divide
// gives one quotient bit per stage, so the stage count follows COORD_WIDTH.
// throughput: one word per cycle while the output is not stalled.
// reset: pipeline emptied, matrix set to identity.
// stall: each stage holds while the one after it is full and stalled, so
// bubbles close up and input is refused only once every stage holds a word.
module homogeneous_point_transform_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [hpt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    hpt_point_if.sink                         i_point,
    hpt_result_if.source                      o_result
);
    import hpt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = COORD_WIDTH + COEF_WIDTH;
    localparam int SW = PW + 2;
    localparam int MW = PW + 1;
    localparam int RW = MW + FRAC_SHIFT;
    localparam int QW = CW + 1;
    localparam int ND = CW + 1;
    localparam int NS = ND + 4;

    logic [CFG_DATA_W-1:0] r_row [NUM_ROWS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= ROW_ONE_RST;
            r_row[1] <= ROW_TWO_RST;
            r_row[2] <= ROW_THREE_RST;
            r_row[3] <= ROW_FOUR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW_ONE:   r_row[0] <= i_cfg_data;
                REG_ROW_TWO:   r_row[1] <= i_cfg_data;
                REG_ROW_THREE: r_row[2] <= i_cfg_data;
                REG_ROW_FOUR:  r_row[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and stall chain
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_take;

    always_comb begin
        w_take[NS] = o_result.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_take[0]) begin
                r_vld[0] <= i_point.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_point.ready = w_take[0];

    // multiply
    logic signed [COEF_WIDTH-1:0] w_coef [NUM_ROWS][NUM_ROWS];
    logic signed [CW-1:0]         w_pt   [NUM_COMP];
    logic signed [PW-1:0]         r_prod [NUM_ROWS][NUM_COMP];

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                w_coef[r][c] = r_row[r][COEF_SLOT*c +: COEF_WIDTH];
            end
        end
        w_pt[0] = i_point.point_x;
        w_pt[1] = i_point.point_y;
        w_pt[2] = i_point.point_z;
    end

    always_ff @(posedge i_clk) begin
        if (w_take[0]) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                for (int r = 0; r < NUM_COMP; r++) begin
                    r_prod[c][r] <= w_pt[r] * w_coef[r][c];
                end
            end
        end
    end

    // column sums in q.28
    logic signed [SW-1:0] r_sum [NUM_ROWS];

    always_ff @(posedge i_clk) begin
        if (w_take[1]) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                r_sum[c] <= SW'(r_prod[c][0]) + SW'(r_prod[c][1]) + SW'(r_prod[c][2])
                          + (SW'(w_coef[3][c]) <<< FRAC_SHIFT);
            end
        end
    end

    // sign and magnitude
    logic [MW-1:0] w_mag [NUM_ROWS];
    logic [MW-1:0] r_den;
    logic [RW-1:0] r_rem0 [NUM_COMP];
    t_side         r_side0;

    always_comb begin
        for (int c = 0; c < NUM_ROWS; c++) begin
            w_mag[c] = r_sum[c][SW-1] ? MW'(-r_sum[c]) : MW'(r_sum[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[2]) begin
            r_den         <= w_mag[3];
            r_side0.fault <= (r_sum[3] == '0);
            for (int c = 0; c < NUM_COMP; c++) begin
                r_rem0[c]       <= RW'(w_mag[c]) << FRAC_SHIFT;
                r_side0.neg[c]  <= r_sum[c][SW-1] ^ r_sum[3][SW-1];
            end
        end
    end

    // divide chain, quotient bit CW first
    logic [MW-1:0] w_den  [ND+1];
    logic [RW-1:0] w_rem  [ND+1][NUM_COMP];
    logic [QW-1:0] w_quo  [ND+1][NUM_COMP];
    t_side         w_side [ND+1];

    always_comb begin
        w_den[0]  = r_den;
        w_side[0] = r_side0;
        for (int c = 0; c < NUM_COMP; c++) begin
            w_rem[0][c] = r_rem0[c];
            w_quo[0][c] = '0;
        end
    end

    for (genvar s = 0; s < ND; s++) begin : g_div
        hpt_div_stage #(
            .RW    (RW),
            .DW    (MW),
            .QW    (QW),
            .SHIFT (CW - s)
        ) u_stage (
            .i_clk  (i_clk),
            .i_en   (w_take[3+s]),
            .i_den  (w_den[s]),
            .i_rem  (w_rem[s]),
            .i_quo  (w_quo[s]),
            .i_side (w_side[s]),
            .o_den  (w_den[s+1]),
            .o_rem  (w_rem[s+1]),
            .o_quo  (w_quo[s+1]),
            .o_side (w_side[s+1])
        );
    end

    // clamp, sign and output register
    logic [QW-1:0]        w_lim  [NUM_COMP];
    logic [QW-1:0]        w_qcl  [NUM_COMP];
    logic [NUM_COMP-1:0]  w_clip;
    logic signed [CW-1:0] n_res  [NUM_COMP];
    logic signed [CW-1:0] r_res  [NUM_COMP];
    logic                 r_fault;
    logic                 r_sat;

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            w_lim[c] = w_side[ND].neg[c] ? (QW'(1) << (CW - 1))
                                         : (QW'(1) << (CW - 1)) - QW'(1);
            w_clip[c] = w_quo[ND][c] > w_lim[c];
            w_qcl[c]  = w_clip[c] ? w_lim[c] : w_quo[ND][c];
            if (w_side[ND].fault) begin
                n_res[c] = '0;
            end else if (w_side[ND].neg[c]) begin
                n_res[c] = CW'(-w_qcl[c]);
            end else begin
                n_res[c] = CW'(w_qcl[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[NS-1]) begin
            r_fault <= w_side[ND].fault;
            r_sat   <= !w_side[ND].fault && (|w_clip);
            for (int c = 0; c < NUM_COMP; c++) begin
                r_res[c] <= n_res[c];
            end
        end
    end

    assign o_result.valid        = r_vld[NS-1];
    assign o_result.result_x     = r_res[0];
    assign o_result.result_y     = r_res[1];
    assign o_result.result_z     = r_res[2];
    assign o_result.divide_fault = r_fault;
    assign o_result.saturated    = r_sat;

`ifndef SYNTHESIS
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.divide_fault |->
            o_result.result_x == '0 && o_result.result_y == '0 &&
            o_result.result_z == '0 && !o_result.saturated)
        else $error("fault word carries nonzero result");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_point.valid && i_point.ready |=> r_vld[0])
        else $error("accepted word not captured");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !o_result.ready |-> !i_point.ready)
        else $error("input taken while pipeline full and stalled");
`endif

endmodule

// ===== sv/hpt_div_stage.sv =====
// one restoring divide stage: one quotient bit for each of three components
// depends on hpt_pkg
module hpt_div_stage #(
    parameter int RW    = 66,
    parameter int DW    = 50,
    parameter int QW    = 33,
    parameter int SHIFT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [DW-1:0]         i_den,
    input  logic [RW-1:0]         i_rem [hpt_pkg::NUM_COMP],
    input  logic [QW-1:0]         i_quo [hpt_pkg::NUM_COMP],
    input  hpt_pkg::t_side        i_side,
    output logic [DW-1:0]         o_den,
    output logic [RW-1:0]         o_rem [hpt_pkg::NUM_COMP],
    output logic [QW-1:0]         o_quo [hpt_pkg::NUM_COMP],
    output hpt_pkg::t_side        o_side
);
    import hpt_pkg::*;

    localparam int EW = RW + QW;

    logic [EW-1:0] w_dsh;
    logic [EW-1:0] w_rext [NUM_COMP];
    logic [RW-1:0] n_rem  [NUM_COMP];
    logic [QW-1:0] n_quo  [NUM_COMP];

    always_comb begin
        w_dsh = EW'(i_den) << SHIFT;
        for (int c = 0; c < NUM_COMP; c++) begin
            w_rext[c] = EW'(i_rem[c]);
            if (w_rext[c] >= w_dsh) begin
                n_rem[c] = RW'(w_rext[c] - w_dsh);
                n_quo[c] = i_quo[c] | (QW'(1) << SHIFT);
            end else begin
                n_rem[c] = i_rem[c];
                n_quo[c] = i_quo[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_den  <= i_den;
            o_side <= i_side;
            for (int c = 0; c < NUM_COMP; c++) begin
                o_rem[c] <= n_rem[c];
                o_quo[c] <= n_quo[c];
            end
        end
    end

endmodule
